[src/lbfv_pkg.sv]
// ----------------------------------------------------------------------------
// lbfv_pkg
// Shared widths, codes, payload type and saturation helper for the Lorentz
// boost pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfv_pkg;

    localparam int COORD_W = 32;
    localparam int BETA_W  = 16;
    localparam int BFRAC   = BETA_W - 1;
    localparam int GFRAC   = 31 - BFRAC;

    // beta.r products and their sum
    localparam int PR_W  = COORD_W + BETA_W;
    localparam int DS_W  = PR_W + 2;
    localparam int DOT_W = DS_W - BFRAC;

    // gamma path
    localparam int B2_W  = 2 * BETA_W;
    localparam int D_W   = 2 * BFRAC + 1;
    localparam int Q_W   = 2 * (GFRAC + BFRAC) + 1;
    localparam int RW1   = D_W + 1;
    localparam int G_W   = 32;
    localparam int X_W   = 2 * G_W;
    localparam int SR_W  = G_W + 3;
    localparam int RW2   = G_W + 2;

    // boost arithmetic
    localparam int CTD_W = DOT_W + 1;
    localparam int M1_W  = G_W + 1 + CTD_W;
    localparam int M2_W  = G_W + 1 + DOT_W;
    localparam int M3_W  = G_W + 1 + COORD_W;
    localparam int KR_W  = M2_W - GFRAC + 1;
    localparam int K_W   = COORD_W + BFRAC + 3;
    localparam int T_W   = BETA_W + K_W;
    localparam int SAT_W = 72;

    localparam int    HALF_B = 1 << (BFRAC - 1);
    localparam int    HALF_G = 1 << (GFRAC - 1);
    localparam int    G_ONE  = 1 << GFRAC;
    localparam longint K_LIM = longint'(1) << (COORD_W + BFRAC + 1);

    localparam int S_TDATA_W = ((4 * COORD_W + 3 * BETA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * COORD_W + 7) / 8) * 8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    typedef struct packed {
        logic                      inv;
        logic signed [DOT_W-1:0]   dot;
        logic signed [BETA_W-1:0]  bz;
        logic signed [BETA_W-1:0]  by;
        logic signed [BETA_W-1:0]  bx;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] ct;
    } t_vec;

    typedef struct packed {
        logic                      flag;
        logic signed [COORD_W-1:0] val;
    } t_sat;

    function automatic t_sat f_sat(input logic signed [SAT_W-1:0] v);
        t_sat res;
        if ((v[SAT_W-1:COORD_W-1] == '0) || (v[SAT_W-1:COORD_W-1] == '1)) begin
            res.flag = 1'b0;
            res.val  = v[COORD_W-1:0];
        end else begin
            res.flag = 1'b1;
            res.val  = v[SAT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                  : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/lbfv_front.sv]
// ----------------------------------------------------------------------------
// lbfv_front
// Two stages: beta squared and beta.r products, then the rounded dot product,
// the invalid check and the divisor 1 - beta^2.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfv_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  lbfv_pkg::t_vec         i_vec,
    output logic                   o_valid,
    output lbfv_pkg::t_vec         o_vec,
    output logic [lbfv_pkg::D_W-1:0] o_d
);
    import lbfv_pkg::*;

    localparam logic [B2_W-1:0] B2_ONE = B2_W'(1) << (2 * BFRAC);

    logic                    r_a_v;
    t_vec                    r_a_p;
    logic signed [PR_W-1:0]  r_prod_x, r_prod_y, r_prod_z;
    logic [B2_W-1:0]         r_b2;

    logic signed [B2_W-1:0]  sq_x, sq_y, sq_z;
    logic [B2_W-1:0]         n_b2;
    logic signed [PR_W-1:0]  n_prod_x, n_prod_y, n_prod_z;

    logic signed [DS_W-1:0]  sum_h;
    logic                    n_inv;
    t_vec                    n_p;
    logic [D_W-1:0]          n_d;

    logic                    r_b_v;
    t_vec                    r_b_p;
    logic [D_W-1:0]          r_d;

    always_comb begin
        sq_x     = i_vec.bx * i_vec.bx;
        sq_y     = i_vec.by * i_vec.by;
        sq_z     = i_vec.bz * i_vec.bz;
        n_b2     = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
        n_prod_x = i_vec.x * i_vec.bx;
        n_prod_y = i_vec.y * i_vec.by;
        n_prod_z = i_vec.z * i_vec.bz;
    end

    always_comb begin
        sum_h = DS_W'(r_prod_x) + DS_W'(r_prod_y) + DS_W'(r_prod_z) + DS_W'(HALF_B);
        n_inv = r_b2 >= B2_ONE;
        n_p     = r_a_p;
        n_p.dot = $signed(sum_h[DS_W-1:BFRAC]);
        n_p.inv = n_inv;
        // any nonzero divisor will do when the result is discarded
        n_d     = n_inv ? D_W'(1) : D_W'(B2_ONE - r_b2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p    <= i_vec;
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
            r_b2     <= n_b2;
            r_b_p    <= n_p;
            r_d      <= n_d;
        end
    end

    assign o_valid = r_b_v;
    assign o_vec   = r_b_p;
    assign o_d     = r_d;

endmodule

`default_nettype wire

[src/lbfv_recip_div.sv]
// ----------------------------------------------------------------------------
// lbfv_recip_div
// Pipelined restoring divider, one quotient bit per stage: q = 2^62 / d.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfv_recip_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  lbfv_pkg::t_vec           i_vec,
    input  logic [lbfv_pkg::D_W-1:0] i_d,
    output logic                     o_valid,
    output lbfv_pkg::t_vec           o_vec,
    output logic [lbfv_pkg::Q_W-1:0] o_q
);
    import lbfv_pkg::*;

    logic             r_v   [0:Q_W-1];
    t_vec             r_p   [0:Q_W-1];
    logic [D_W-1:0]   r_d   [0:Q_W-1];
    logic [RW1-1:0]   r_rem [0:Q_W-1];
    logic [Q_W-1:0]   r_q   [0:Q_W-1];

    logic             s_v   [0:Q_W-1];
    t_vec             s_p   [0:Q_W-1];
    logic [D_W-1:0]   s_d   [0:Q_W-1];
    logic [RW1-1:0]   s_rem [0:Q_W-1];
    logic [Q_W-1:0]   s_q   [0:Q_W-1];

    logic [RW1-1:0]   sh    [0:Q_W-1];
    logic             ge    [0:Q_W-1];
    logic [RW1-1:0]   n_rem [0:Q_W-1];
    logic [Q_W-1:0]   n_q   [0:Q_W-1];

    always_comb begin
        s_v[0]   = i_valid;
        s_p[0]   = i_vec;
        s_d[0]   = i_d;
        s_rem[0] = '0;
        s_q[0]   = '0;
        for (int j = 1; j < Q_W; j++) begin
            s_v[j]   = r_v[j-1];
            s_p[j]   = r_p[j-1];
            s_d[j]   = r_d[j-1];
            s_rem[j] = r_rem[j-1];
            s_q[j]   = r_q[j-1];
        end
    end

    // the dividend has its only set bit at the top
    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            sh[j]    = {s_rem[j][RW1-2:0], (j == 0)};
            ge[j]    = sh[j] >= RW1'(s_d[j]);
            n_rem[j] = ge[j] ? sh[j] - RW1'(s_d[j]) : sh[j];
            n_q[j]   = {s_q[j][Q_W-2:0], ge[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < Q_W; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < Q_W; j++) r_v[j] <= s_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_p[j]   <= s_p[j];
                r_d[j]   <= s_d[j];
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_vec   = r_p[Q_W-1];
    assign o_q     = r_q[Q_W-1];

endmodule

`default_nettype wire

[src/lbfv_isqrt.sv]
// ----------------------------------------------------------------------------
// lbfv_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage:
// gamma = floor(sqrt(q)).
// ----------------------------------------------------------------------------
`default_nettype none

module lbfv_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  lbfv_pkg::t_vec           i_vec,
    input  logic [lbfv_pkg::Q_W-1:0] i_q,
    output logic                     o_valid,
    output lbfv_pkg::t_vec           o_vec,
    output logic [lbfv_pkg::G_W-1:0] o_g
);
    import lbfv_pkg::*;

    logic             r_v    [0:G_W-1];
    t_vec             r_p    [0:G_W-1];
    logic [X_W-1:0]   r_x    [0:G_W-1];
    logic [SR_W-1:0]  r_rem  [0:G_W-1];
    logic [G_W-1:0]   r_root [0:G_W-1];

    logic             s_v    [0:G_W-1];
    t_vec             s_p    [0:G_W-1];
    logic [X_W-1:0]   s_x    [0:G_W-1];
    logic [SR_W-1:0]  s_rem  [0:G_W-1];
    logic [G_W-1:0]   s_root [0:G_W-1];

    logic [SR_W-1:0]  sh     [0:G_W-1];
    logic [SR_W-1:0]  trial  [0:G_W-1];
    logic             ge     [0:G_W-1];
    logic [SR_W-1:0]  n_rem  [0:G_W-1];
    logic [G_W-1:0]   n_root [0:G_W-1];
    logic [X_W-1:0]   n_x    [0:G_W-1];

    always_comb begin
        s_v[0]    = i_valid;
        s_p[0]    = i_vec;
        s_x[0]    = X_W'(i_q);
        s_rem[0]  = '0;
        s_root[0] = '0;
        for (int j = 1; j < G_W; j++) begin
            s_v[j]    = r_v[j-1];
            s_p[j]    = r_p[j-1];
            s_x[j]    = r_x[j-1];
            s_rem[j]  = r_rem[j-1];
            s_root[j] = r_root[j-1];
        end
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
        for (int j = 0; j < G_W; j++) begin
            sh[j]     = {s_rem[j][SR_W-3:0], s_x[j][X_W-1 -: 2]};
            trial[j]  = {1'b0, s_root[j], 2'b01};
            ge[j]     = sh[j] >= trial[j];
            n_rem[j]  = ge[j] ? sh[j] - trial[j] : sh[j];
            n_root[j] = {s_root[j][G_W-2:0], ge[j]};
            n_x[j]    = {s_x[j][X_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < G_W; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < G_W; j++) r_v[j] <= s_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < G_W; j++) begin
                r_p[j]    <= s_p[j];
                r_x[j]    <= n_x[j];
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_valid = r_v[G_W-1];
    assign o_vec   = r_p[G_W-1];
    assign o_g     = r_root[G_W-1];

endmodule

`default_nettype wire

[src/lbfv_coef_div.sv]
// ----------------------------------------------------------------------------
// lbfv_coef_div
// Squares gamma, then a pipelined divider, one bit per stage:
// c = gamma^2 / (gamma + 1), which equals (gamma - 1) / beta^2.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfv_coef_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  lbfv_pkg::t_vec           i_vec,
    input  logic [lbfv_pkg::G_W-1:0] i_g,
    output logic                     o_valid,
    output lbfv_pkg::t_vec           o_vec,
    output logic [lbfv_pkg::G_W-1:0] o_g,
    output logic [lbfv_pkg::G_W-1:0] o_c
);
    import lbfv_pkg::*;

    logic             r_h_v;
    t_vec             r_h_p;
    logic [G_W-1:0]   r_h_g;
    logic [G_W:0]     r_h_dv;
    logic [X_W-1:0]   r_h_nn;
    logic [X_W-1:0]   n_nn;
    logic [G_W:0]     n_dv;

    logic             r_v   [0:G_W-1];
    t_vec             r_p   [0:G_W-1];
    logic [G_W-1:0]   r_g   [0:G_W-1];
    logic [G_W:0]     r_dv  [0:G_W-1];
    logic [G_W-1:0]   r_x   [0:G_W-1];
    logic [RW2-1:0]   r_rem [0:G_W-1];
    logic [G_W-1:0]   r_c   [0:G_W-1];

    logic             s_v   [0:G_W-1];
    t_vec             s_p   [0:G_W-1];
    logic [G_W-1:0]   s_g   [0:G_W-1];
    logic [G_W:0]     s_dv  [0:G_W-1];
    logic [G_W-1:0]   s_x   [0:G_W-1];
    logic [RW2-1:0]   s_rem [0:G_W-1];
    logic [G_W-1:0]   s_c   [0:G_W-1];

    logic [RW2-1:0]   sh    [0:G_W-1];
    logic             ge    [0:G_W-1];
    logic [RW2-1:0]   n_rem [0:G_W-1];
    logic [G_W-1:0]   n_c   [0:G_W-1];
    logic [G_W-1:0]   n_x   [0:G_W-1];

    assign n_nn = i_g * i_g;
    assign n_dv = {1'b0, i_g} + (G_W+1)'(G_ONE);

    // the quotient stays below 2^G_W, so the upper half starts as remainder
    always_comb begin
        s_v[0]   = r_h_v;
        s_p[0]   = r_h_p;
        s_g[0]   = r_h_g;
        s_dv[0]  = r_h_dv;
        s_x[0]   = r_h_nn[G_W-1:0];
        s_rem[0] = RW2'(r_h_nn[X_W-1:G_W]);
        s_c[0]   = '0;
        for (int j = 1; j < G_W; j++) begin
            s_v[j]   = r_v[j-1];
            s_p[j]   = r_p[j-1];
            s_g[j]   = r_g[j-1];
            s_dv[j]  = r_dv[j-1];
            s_x[j]   = r_x[j-1];
            s_rem[j] = r_rem[j-1];
            s_c[j]   = r_c[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < G_W; j++) begin
            sh[j]    = {s_rem[j][RW2-2:0], s_x[j][G_W-1]};
            ge[j]    = sh[j] >= RW2'(s_dv[j]);
            n_rem[j] = ge[j] ? sh[j] - RW2'(s_dv[j]) : sh[j];
            n_c[j]   = {s_c[j][G_W-2:0], ge[j]};
            n_x[j]   = {s_x[j][G_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
            for (int j = 0; j < G_W; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_h_v <= i_valid;
            for (int j = 0; j < G_W; j++) r_v[j] <= s_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h_p  <= i_vec;
            r_h_g  <= i_g;
            r_h_dv <= n_dv;
            r_h_nn <= n_nn;
            for (int j = 0; j < G_W; j++) begin
                r_p[j]   <= s_p[j];
                r_g[j]   <= s_g[j];
                r_dv[j]  <= s_dv[j];
                r_x[j]   <= n_x[j];
                r_rem[j] <= n_rem[j];
                r_c[j]   <= n_c[j];
            end
        end
    end

    assign o_valid = r_v[G_W-1];
    assign o_vec   = r_p[G_W-1];
    assign o_g     = r_g[G_W-1];
    assign o_c     = r_c[G_W-1];

endmodule

`default_nettype wire

[src/lbfv_back.sv]
// ----------------------------------------------------------------------------
// lbfv_back
// Four stages: gamma and coefficient products, rounding and clamp of the
// spatial factor k, beta times k, final sums with saturation and status.
// The last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfv_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  lbfv_pkg::t_vec                      i_vec,
    input  logic [lbfv_pkg::G_W-1:0]            i_g,
    input  logic [lbfv_pkg::G_W-1:0]            i_c,
    output logic                                o_valid,
    output logic signed [lbfv_pkg::COORD_W-1:0] o_ct,
    output logic signed [lbfv_pkg::COORD_W-1:0] o_x,
    output logic signed [lbfv_pkg::COORD_W-1:0] o_y,
    output logic signed [lbfv_pkg::COORD_W-1:0] o_z,
    output logic [1:0]                          o_status
);
    import lbfv_pkg::*;

    // stage 1
    logic signed [CTD_W-1:0]   ctd;
    logic signed [G_W:0]       gs, cs;
    logic signed [M1_W-1:0]    n_m1;
    logic signed [M2_W-1:0]    n_m2;
    logic signed [M3_W-1:0]    n_m3;
    logic                      r_s1_v;
    t_vec                      r_s1_p;
    logic signed [M1_W-1:0]    r_m1;
    logic signed [M2_W-1:0]    r_m2;
    logic signed [M3_W-1:0]    r_m3;

    // stage 2
    logic signed [M1_W-1:0]    m1h;
    logic signed [M2_W-1:0]    m2h;
    logic signed [M3_W-1:0]    m3h;
    logic signed [KR_W-1:0]    kr;
    logic signed [K_W-1:0]     n_k;
    t_sat                      ct_s;
    logic                      r_s2_v;
    t_vec                      r_s2_p;
    logic signed [K_W-1:0]     r_k;
    logic signed [COORD_W-1:0] r_ct2;
    logic                      r_sat2;

    // stage 3
    logic signed [T_W-1:0]     n_tx, n_ty, n_tz;
    logic                      r_s3_v;
    t_vec                      r_s3_p;
    logic signed [T_W-1:0]     r_tx, r_ty, r_tz;
    logic signed [COORD_W-1:0] r_ct3;
    logic                      r_sat3;

    // stage 4
    logic signed [T_W-1:0]     txh, tyh, tzh;
    t_sat                      x_s, y_s, z_s;
    logic                      any_sat;
    logic                      r_o_v;
    logic signed [COORD_W-1:0] r_o_ct, r_o_x, r_o_y, r_o_z;
    logic [1:0]                r_o_st;

    always_comb begin
        ctd  = CTD_W'(i_vec.ct) - CTD_W'(i_vec.dot);
        gs   = $signed({1'b0, i_g});
        cs   = $signed({1'b0, i_c});
        n_m1 = gs * ctd;
        n_m2 = cs * i_vec.dot;
        n_m3 = gs * i_vec.ct;
    end

    always_comb begin
        m1h  = r_m1 + M1_W'(HALF_G);
        m2h  = r_m2 + M2_W'(HALF_G);
        m3h  = r_m3 + M3_W'(HALF_G);
        ct_s = f_sat(SAT_W'($signed(m1h[M1_W-1:GFRAC])));
        kr   = KR_W'($signed(m2h[M2_W-1:GFRAC])) - KR_W'($signed(m3h[M3_W-1:GFRAC]));
        // clamp only matters where the spatial results saturate anyway
        if (kr > KR_W'(K_LIM)) begin
            n_k = K_W'(K_LIM);
        end else if (kr < -KR_W'(K_LIM)) begin
            n_k = -K_W'(K_LIM);
        end else begin
            n_k = K_W'(kr);
        end
    end

    always_comb begin
        n_tx = r_s2_p.bx * r_k;
        n_ty = r_s2_p.by * r_k;
        n_tz = r_s2_p.bz * r_k;
    end

    always_comb begin
        txh     = r_tx + T_W'(HALF_B);
        tyh     = r_ty + T_W'(HALF_B);
        tzh     = r_tz + T_W'(HALF_B);
        x_s     = f_sat(SAT_W'(r_s3_p.x) + SAT_W'($signed(txh[T_W-1:BFRAC])));
        y_s     = f_sat(SAT_W'(r_s3_p.y) + SAT_W'($signed(tyh[T_W-1:BFRAC])));
        z_s     = f_sat(SAT_W'(r_s3_p.z) + SAT_W'($signed(tzh[T_W-1:BFRAC])));
        any_sat = r_sat3 | x_s.flag | y_s.flag | z_s.flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_o_v  <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_p <= i_vec;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
            r_m3   <= n_m3;
            r_s2_p <= r_s1_p;
            r_k    <= n_k;
            r_ct2  <= ct_s.val;
            r_sat2 <= ct_s.flag;
            r_s3_p <= r_s2_p;
            r_tx   <= n_tx;
            r_ty   <= n_ty;
            r_tz   <= n_tz;
            r_ct3  <= r_ct2;
            r_sat3 <= r_sat2;
            if (r_s3_p.inv) begin
                r_o_ct <= '0;
                r_o_x  <= '0;
                r_o_y  <= '0;
                r_o_z  <= '0;
                r_o_st <= ST_INVALID;
            end else begin
                r_o_ct <= r_ct3;
                r_o_x  <= x_s.val;
                r_o_y  <= y_s.val;
                r_o_z  <= z_s.val;
                r_o_st <= any_sat ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid  = r_o_v;
    assign o_ct     = r_o_ct;
    assign o_x      = r_o_x;
    assign o_y      = r_o_y;
    assign o_z      = r_o_z;
    assign o_status = r_o_st;

endmodule

`default_nettype wire

[src/lorentz_boost_four_vector_core.sv]
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector_core
// Lorentz boost of a Q16.16 four-vector by a Q0.15 velocity, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while the output side does not stall and
// returns one result per transaction, in order. The pipeline depth is set by
// the gamma path: a 63-stage reciprocal divider, a 32-stage square root, a
// squaring stage and a 32-stage coefficient divider, plus two front and four
// back stages. A stall on the output freezes the whole pipeline, so tready on
// the input follows output readiness. tuser on the output carries the status:
// ok, beta not below one (coordinates zero), or saturated.
`default_nettype none

module lorentz_boost_four_vector_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // ct_in, x_in, y_in, z_in, beta_x, beta_y, beta_z
    input  logic [lbfv_pkg::S_TDATA_W-1:0]        i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // ct_out, x_out, y_out, z_out
    output logic [lbfv_pkg::M_TDATA_W-1:0]        o_m_axis_tdata,
    // status
    output logic [1:0]                            o_m_axis_tuser
);
    import lbfv_pkg::*;

    logic                      en;
    t_vec                      in_vec;

    logic                      f_v;
    t_vec                      f_p;
    logic [D_W-1:0]            f_d;
    logic                      r1_v;
    t_vec                      r1_p;
    logic [Q_W-1:0]            r1_q;
    logic                      sq_v;
    t_vec                      sq_p;
    logic [G_W-1:0]            sq_g;
    logic                      cd_v;
    t_vec                      cd_p;
    logic [G_W-1:0]            cd_g, cd_c;
    logic signed [COORD_W-1:0] out_ct, out_x, out_y, out_z;

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_comb begin
        in_vec     = '0;
        in_vec.ct  = i_s_axis_tdata[0*COORD_W +: COORD_W];
        in_vec.x   = i_s_axis_tdata[1*COORD_W +: COORD_W];
        in_vec.y   = i_s_axis_tdata[2*COORD_W +: COORD_W];
        in_vec.z   = i_s_axis_tdata[3*COORD_W +: COORD_W];
        in_vec.bx  = i_s_axis_tdata[4*COORD_W +: BETA_W];
        in_vec.by  = i_s_axis_tdata[4*COORD_W+BETA_W +: BETA_W];
        in_vec.bz  = i_s_axis_tdata[4*COORD_W+2*BETA_W +: BETA_W];
    end

    lbfv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_vec   (in_vec),
        .o_valid (f_v),
        .o_vec   (f_p),
        .o_d     (f_d)
    );

    lbfv_recip_div u_recip_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_vec   (f_p),
        .i_d     (f_d),
        .o_valid (r1_v),
        .o_vec   (r1_p),
        .o_q     (r1_q)
    );

    lbfv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_vec   (r1_p),
        .i_q     (r1_q),
        .o_valid (sq_v),
        .o_vec   (sq_p),
        .o_g     (sq_g)
    );

    lbfv_coef_div u_coef_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_vec   (sq_p),
        .i_g     (sq_g),
        .o_valid (cd_v),
        .o_vec   (cd_p),
        .o_g     (cd_g),
        .o_c     (cd_c)
    );

    lbfv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (cd_v),
        .i_vec    (cd_p),
        .i_g      (cd_g),
        .i_c      (cd_c),
        .o_valid  (o_m_axis_tvalid),
        .o_ct     (out_ct),
        .o_x      (out_x),
        .o_y      (out_y),
        .o_z      (out_z),
        .o_status (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = M_TDATA_W'({out_z, out_y, out_x, out_ct});

    // an invalid velocity returns a zero four-vector
    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_INVALID)) |-> (o_m_axis_tdata == '0))
        else $error("invalid status with nonzero coordinates");

    // the status code is always one of the defined codes
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == ST_OK) || (o_m_axis_tuser == ST_INVALID) ||
                             (o_m_axis_tuser == ST_SAT)))
        else $error("unused status code on output");

    // a saturated result has at least one coordinate pinned at a rail
    a_sat_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_SAT)) |->
        ((out_ct == {1'b0, {(COORD_W-1){1'b1}}}) || (out_ct == {1'b1, {(COORD_W-1){1'b0}}}) ||
         (out_x  == {1'b0, {(COORD_W-1){1'b1}}}) || (out_x  == {1'b1, {(COORD_W-1){1'b0}}}) ||
         (out_y  == {1'b0, {(COORD_W-1){1'b1}}}) || (out_y  == {1'b1, {(COORD_W-1){1'b0}}}) ||
         (out_z  == {1'b0, {(COORD_W-1){1'b1}}}) || (out_z  == {1'b1, {(COORD_W-1){1'b0}}})))
        else $error("saturation status without a saturated coordinate");

endmodule

`default_nettype wire

[dv/tb_lorentz_boost_four_vector_core.sv]
// ----------------------------------------------------------------------------
// tb_lorentz_boost_four_vector_core
// Streams four-vectors and velocities through the boost core under random
// backpressure, predicts the boosted vector and status in fixed point unless a
// directed row gives them, and compares each output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lorentz_boost_four_vector_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lbfv_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int N_RANDOM       = 550;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [COORD_W-1:0] ct, x, y, z;
        logic signed [BETA_W-1:0]  bx, by, bz;
    } t_event;

    typedef struct {
        logic signed [COORD_W-1:0] ct, x, y, z;
        logic [1:0]                status;
    } t_boosted;

    typedef struct {
        t_event   ev;
        bit       typed;
        t_boosted res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [1:0]           o_m_axis_tuser;

    lorentz_boost_four_vector_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_boosted expected_q[$];
    t_event   pending_ev;
    bit       pending_typed;
    t_boosted pending_res;
    int       errors;
    int       idle_cycles;
    bit       no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // round half up, then drop n fraction bits
    function automatic t_wide round_shift(t_wide v, int n);
        return (v + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    // {overflow flag, saturated coordinate}
    function automatic logic [COORD_W:0] clip_coord(t_wide v);
        if (v > t_wide'(32'sh7fffffff))
            return {1'b1, 32'h7fffffff};
        if (v < -t_wide'(64'sh80000000))
            return {1'b1, 32'h80000000};
        return {1'b0, v[COORD_W-1:0]};
    endfunction

    function automatic t_boosted boost_predict(t_event e);
        t_wide             r[3], b[3], ct, dotv, gam, coef, kv, lim;
        longint unsigned   b2, gu, cu;
        logic [COORD_W:0]  cl;
        logic              sat;
        t_boosted          o;
        r[0] = e.x;  r[1] = e.y;  r[2] = e.z;
        b[0] = e.bx; b[1] = e.by; b[2] = e.bz;
        ct   = e.ct;
        b2   = 64'(b[0] * b[0] + b[1] * b[1] + b[2] * b[2]);
        if (b2 >= (64'd1 << (2 * BFRAC))) begin
            o.ct = '0; o.x = '0; o.y = '0; o.z = '0;
            o.status = ST_INVALID;
            return o;
        end
        gu   = int_sqrt((64'd1 << 62) / ((64'd1 << (2 * BFRAC)) - b2));
        cu   = (gu * gu) / (gu + (64'd1 << GFRAC));
        gam  = $signed({64'd0, gu});
        coef = $signed({64'd0, cu});
        dotv = round_shift(r[0] * b[0] + r[1] * b[1] + r[2] * b[2], BFRAC);
        cl   = clip_coord(round_shift(gam * (ct - dotv), GFRAC));
        sat  = cl[COORD_W];
        o.ct = cl[COORD_W-1:0];
        kv   = round_shift(coef * dotv, GFRAC) - round_shift(gam * ct, GFRAC);
        lim  = t_wide'(1) <<< (COORD_W + BFRAC + 1);
        if (kv > lim) kv = lim;
        else if (kv < -lim) kv = -lim;
        cl  = clip_coord(r[0] + round_shift(kv * b[0], BFRAC)); sat |= cl[COORD_W];
        o.x = cl[COORD_W-1:0];
        cl  = clip_coord(r[1] + round_shift(kv * b[1], BFRAC)); sat |= cl[COORD_W];
        o.y = cl[COORD_W-1:0];
        cl  = clip_coord(r[2] + round_shift(kv * b[2], BFRAC)); sat |= cl[COORD_W];
        o.z = cl[COORD_W-1:0];
        o.status = sat ? ST_SAT : ST_OK;
        return o;
    endfunction

    task automatic send_event(t_event e, bit typed, t_boosted res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        pending_ev      = e;
        pending_typed   = typed;
        pending_res     = res;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {e.bz, e.by, e.bx, e.z, e.y, e.x, e.ct};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $signed(32'($urandom_range(0, 2097152))) - 32'sd1048576;
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2:       return $signed(32'($urandom_range(0, 65536 * 64))) - 32'sd2097152;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_event rand_event();
        t_event e;
        e.ct = rand_coord(); e.x = rand_coord(); e.y = rand_coord(); e.z = rand_coord();
        e.bx = '0; e.by = '0; e.bz = '0;
        case ($urandom_range(0, 7))
            0: begin
                // full range, often not below one
                e.bx = 16'($urandom); e.by = 16'($urandom); e.bz = 16'($urandom);
            end
            1, 2: begin
                // one random axis up to the limit, sometimes with beta_x at its limit as well
                case ($urandom_range(0, 2))
                    0: e.bx = 16'($urandom);
                    1: e.by = 16'($urandom);
                    default: e.bz = 16'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0) e.bx = $urandom_range(0, 1) ? 16'sh7fff : -16'sh7fff;
            end
            7: begin
                e.bx = $signed(16'($urandom_range(0, 64))) - 16'sd32;
                e.by = $signed(16'($urandom_range(0, 64))) - 16'sd32;
            end
            default: begin
                e.bx = $signed(16'($urandom_range(0, 36000))) - 16'sd18000;
                e.by = $signed(16'($urandom_range(0, 36000))) - 16'sd18000;
                e.bz = $signed(16'($urandom_range(0, 36000))) - 16'sd18000;
            end
        endcase
        return e;
    endfunction

    // expectations are queued here and outputs checked here
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_q.push_back(pending_typed ? pending_res : boost_predict(pending_ev));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected output transaction %h status %0d", $realtime,
                             o_m_axis_tdata, o_m_axis_tuser);
                    errors++;
                end else begin
                    t_boosted ex;
                    ex = expected_q.pop_front();
                    if (o_m_axis_tdata !== {ex.z, ex.y, ex.x, ex.ct}) begin
                        $display("%0t: coords expected ct %h x %h y %h z %h, got %h",
                                 $realtime, ex.ct, ex.x, ex.y, ex.z, o_m_axis_tdata);
                        errors++;
                    end
                    if (o_m_axis_tuser !== ex.status) begin
                        $display("%0t: status expected %0d, got %0d", $realtime,
                                 ex.status, o_m_axis_tuser);
                        errors++;
                    end
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout, %0d results outstanding", expected_q.size());
            $display("tb_lorentz_boost_four_vector_core failed");
            $finish;
        end
    end

    // output side backpressure
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    initial begin
        t_row     rows[$];
        t_row     rw;
        t_boosted none;
        t_event   e;
        errors          = 0;
        idle_cycles     = 0;
        no_idle         = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        none            = '{default: '0};

        // zero velocity passes the vector through
        rw = '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0}, 1,
               '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, ST_OK}};
        rows.push_back(rw);
        rw = '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0}, 1,
               '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, ST_OK}};
        rows.push_back(rw);
        rw = '{'{32'sh00010000, -32'sh1, 32'sh12345678, 32'sh0, 0, 0, 0}, 1,
               '{32'sh00010000, -32'sh1, 32'sh12345678, 32'sh0, ST_OK}};
        rows.push_back(rw);
        // beta not below one gives zeros
        rw = '{'{32'sh00010000, 32'sh1, 32'sh2, 32'sh3, -16'sh8000, 0, 0}, 1,
               '{0, 0, 0, 0, ST_INVALID}};
        rows.push_back(rw);
        rw = '{'{32'sh7fffffff, 32'sh1, 32'sh2, 32'sh3, 0, -16'sh8000, 0}, 1,
               '{0, 0, 0, 0, ST_INVALID}};
        rows.push_back(rw);
        rw = '{'{32'sh1, 32'sh1, 32'sh2, 32'sh3, 0, 0, -16'sh8000}, 1,
               '{0, 0, 0, 0, ST_INVALID}};
        rows.push_back(rw);
        rw = '{'{32'sh1, 32'sh1, 32'sh2, 32'sh3, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1,
               '{0, 0, 0, 0, ST_INVALID}};
        rows.push_back(rw);
        // predicted rows: fastest beta along each axis, saturation, small cases
        rw = '{'{32'sh00010000, 32'sh0, 32'sh0, 32'sh0, 16'sh7fff, 0, 0}, 0, none};
        rows.push_back(rw);
        rw = '{'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh0, 16'sh7fff, 0, 0}, 0, none};
        rows.push_back(rw);
        rw = '{'{32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh80000000, 0, -16'sh7fff, 0}, 0, none};
        rows.push_back(rw);
        rw = '{'{32'sh00100000, 32'sh0, 32'sh0, 32'sh00100000, 0, 0, 16'sh7fff}, 0, none};
        rows.push_back(rw);
        rw = '{'{32'sh00020000, 32'sh00010000, 32'shffff0000, 32'sh0, 16'sh4000, 16'sh4000, 0},
               0, none};
        rows.push_back(rw);
        rw = '{'{32'sh0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 16'sh1, -16'sh1, 16'sh1},
               0, none};
        rows.push_back(rw);
        rw = '{'{-32'sh00050000, 32'sh00030000, 32'sh0, 32'sh0, -16'sh6000, 16'sh2000,
                 -16'sh1000}, 0, none};
        rows.push_back(rw);
        rw = '{'{32'sh40000000, 32'shc0000000, 32'sh40000000, 32'shc0000000, 16'sh49e6,
                 16'sh49e6, 16'sh49e6}, 0, none};
        rows.push_back(rw);
        rw = '{'{32'shffffffff, 32'sh7fffffff, 32'sh80000000, 32'sh55555555, 16'sh5555,
                 -16'sh2aaa, 16'sh0}, 0, none};
        rows.push_back(rw);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].res);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        // let the pipeline run dry before the random part
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 50) no_idle = ~no_idle;
            e = rand_event();
            send_event(e, 1'b0, none);
            if (n == N_RANDOM / 2) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_lorentz_boost_four_vector_core passed");
        end else begin
            $display("tb_lorentz_boost_four_vector_core failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/lbfv_pkg.sv
src/lbfv_front.sv
src/lbfv_recip_div.sv
src/lbfv_isqrt.sv
src/lbfv_coef_div.sv
src/lbfv_back.sv
src/lorentz_boost_four_vector_core.sv
dv/tb_lorentz_boost_four_vector_core.sv
